[rtl/core/bfsa_pkg.sv]
// ---------------------------------------------------------------------------
// bfsa_pkg
// Shared types and result codes of the best-fit segment allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_REQ  = 2'd3;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic init;       // write the single free segment after reset
        logic accept;     // latch the request word, rewind the scan
        logic scan;       // step the table scan
        logic decide;     // settle the result, update the chosen entry
        logic shift;      // step the table shift-up
        logic write_new;  // write the free remainder, bump the count
        logic load_out;   // move the result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic need_split;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/bfsa_ctrl.sv]
// ---------------------------------------------------------------------------
// bfsa_ctrl
// Sequencer of the allocator: init, scan, decide, shift, write, deliver.
// ---------------------------------------------------------------------------
`default_nettype none

module bfsa_ctrl
    import bfsa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] ST_INIT      = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_SCAN      = 3'd2;
    localparam logic [2:0] ST_DECIDE    = 3'd3;
    localparam logic [2:0] ST_SHIFT     = 3'd4;
    localparam logic [2:0] ST_WRITE_NEW = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_split ? ST_SHIFT : ST_DONE;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = ST_WRITE_NEW;
                end
            end
            ST_WRITE_NEW:
            begin
                cmd.write_new = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bfsa_datapath.sv]
// ---------------------------------------------------------------------------
// bfsa_datapath
// Segment memory, scan and best-fit compare, shift-up, result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module bfsa_datapath
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ADDR_BITS:0]   cfg_wr_data,
    input  wire logic                 req_type,
    input  wire logic [ADDR_BITS:0]   req_size,
    input  wire logic [ADDR_BITS-1:0] release_start,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [ADDR_BITS-1:0]      alloc_start
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int LW = ADDR_BITS + 1;
    localparam int EW = 2 * ADDR_BITS + 2;

    localparam logic [LW-1:0] SIZE_SPAN  = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [LW-1:0] SIZE_RESET = (ADDR_BITS >= 16) ? LW'(65536) : SIZE_SPAN;
    localparam logic [CW-1:0] COUNT_MAX  = CW'(MAX_SEGMENTS);

    // entry layout: {free, length, start}
    logic [EW-1:0]        seg_mem [MAX_SEGMENTS];

    logic [EW-1:0]        rd_data_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 rd_vld_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        count_reg;
    logic [LW-1:0]        memsize_reg;
    logic                 req_type_reg;
    logic [LW-1:0]        req_size_reg;
    logic [ADDR_BITS-1:0] rel_reg;
    logic                 found_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [LW-1:0]        best_diff_reg;
    logic [EW-1:0]        best_ent_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [ADDR_BITS-1:0] res_start_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ADDR_BITS-1:0] out_start_reg;

    logic [LW-1:0]        cfg_sat;
    logic [LW-1:0]        init_len;
    logic                 scan_more;
    logic                 shift_more;
    logic [CW-1:0]        best_next;
    logic [CW-1:0]        idx_dec;
    logic                 rd_en;
    logic [IW-1:0]        raddr;
    logic                 mem_we;
    logic [IW-1:0]        waddr;
    logic [EW-1:0]        wdata;

    logic [ADDR_BITS-1:0] ent_start;
    logic [LW-1:0]        ent_len;
    logic                 ent_free;
    logic [LW-1:0]        ent_diff;
    logic                 take;

    logic [ADDR_BITS-1:0] best_start;
    logic [LW-1:0]        best_len;
    logic                 best_free;
    logic [ADDR_BITS-1:0] new_start;
    logic [STATUS_W-1:0]  dec_status;
    logic [ADDR_BITS-1:0] dec_start;
    logic                 dec_write;
    logic [EW-1:0]        dec_wdata;
    logic                 dec_split;

    // saturate a written size into one unit up to the full address span
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_sat = LW'(1);
        end
        else if (cfg_wr_data > SIZE_SPAN)
        begin
            cfg_sat = SIZE_SPAN;
        end
        else
        begin
            cfg_sat = cfg_wr_data;
        end
    end

    assign init_len = cfg_wr_en ? cfg_sat : memsize_reg;

    // scan and shift pointers
    assign scan_more  = idx_reg < count_reg;
    assign best_next  = CW'(best_idx_reg) + CW'(1);
    assign shift_more = idx_reg > best_next;
    assign idx_dec    = idx_reg - CW'(1);

    always_comb
    begin
        rd_en = 1'b0;
        raddr = idx_reg[IW-1:0];
        if (cmd.scan && scan_more)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.shift && shift_more)
        begin
            rd_en = 1'b1;
            raddr = idx_dec[IW-1:0];
        end
    end

    // best-fit compare on the entry just read
    assign ent_start = rd_data_reg[ADDR_BITS-1:0];
    assign ent_len   = rd_data_reg[EW-2:ADDR_BITS];
    assign ent_free  = rd_data_reg[EW-1];
    assign ent_diff  = ent_len - req_size_reg;

    always_comb
    begin
        if (req_type_reg == REQ_RELEASE)
        begin
            take = !found_reg && (ent_start == rel_reg);
        end
        else
        begin
            take = ent_free && (ent_len >= req_size_reg)
                   && (!found_reg || (ent_diff < best_diff_reg));
        end
    end

    // result of the scan
    assign best_start = best_ent_reg[ADDR_BITS-1:0];
    assign best_len   = best_ent_reg[EW-2:ADDR_BITS];
    assign best_free  = best_ent_reg[EW-1];
    assign new_start  = best_start + req_size_reg[ADDR_BITS-1:0];

    always_comb
    begin
        dec_status = STATUS_OK;
        dec_start  = '0;
        dec_write  = 1'b0;
        dec_wdata  = '0;
        dec_split  = 1'b0;
        if (req_type_reg == REQ_RELEASE)
        begin
            if (!found_reg || best_free)
            begin
                dec_status = STATUS_BAD_REQ;
            end
            else
            begin
                dec_start = rel_reg;
                dec_write = 1'b1;
                dec_wdata = {1'b1, best_len, best_start};
            end
        end
        else if (req_size_reg == '0)
        begin
            dec_status = STATUS_BAD_REQ;
        end
        else if (!found_reg)
        begin
            dec_status = STATUS_NO_FIT;
        end
        else if ((best_diff_reg != '0) && (count_reg >= COUNT_MAX))
        begin
            dec_status = STATUS_FULL;
        end
        else
        begin
            dec_start = best_start;
            dec_write = 1'b1;
            dec_wdata = {1'b0, req_size_reg, best_start};
            dec_split = best_diff_reg != '0;
        end
    end

    // single write port of the segment memory
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = '0;
        wdata  = '0;
        if (cfg_wr_en || cmd.init)
        begin
            mem_we = 1'b1;
            wdata  = {1'b1, init_len, {ADDR_BITS{1'b0}}};
        end
        else if (cmd.decide && dec_write)
        begin
            mem_we = 1'b1;
            waddr  = best_idx_reg;
            wdata  = dec_wdata;
        end
        else if (cmd.shift && rd_vld_reg)
        begin
            mem_we = 1'b1;
            waddr  = rd_idx_reg + IW'(1);
            wdata  = rd_data_reg;
        end
        else if (cmd.write_new)
        begin
            mem_we = 1'b1;
            waddr  = best_idx_reg + IW'(1);
            wdata  = {1'b1, best_diff_reg, new_start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= seg_mem[raddr];
            rd_idx_reg  <= raddr;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= CW'(1);
            memsize_reg   <= SIZE_RESET;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (rd_en)
            begin
                idx_reg <= cmd.scan ? idx_reg + CW'(1) : idx_dec;
            end
            if (cmd.accept)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan && rd_vld_reg && take)
            begin
                found_reg <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                memsize_reg <= cfg_sat;
            end
            if (cfg_wr_en || cmd.init)
            begin
                count_reg <= CW'(1);
            end
            else if (cmd.write_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg <= req_type;
            req_size_reg <= req_size;
            rel_reg      <= release_start;
        end
        if (cmd.scan && rd_vld_reg && take)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_diff_reg <= ent_diff;
            best_ent_reg  <= rd_data_reg;
        end
        if (cmd.decide)
        begin
            res_status_reg <= dec_status;
            res_start_reg  <= dec_start;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
        end
    end

    assign sts.scan_done  = !scan_more && !rd_vld_reg;
    assign sts.shift_done = !shift_more && !rd_vld_reg;
    assign sts.need_split = dec_split;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign alloc_start = out_start_reg;

endmodule

`default_nettype wire

[rtl/core/best_fit_segment_allocator.sv]
// ---------------------------------------------------------------------------
// best_fit_segment_allocator
// Best-fit allocator over an address-ordered table of memory segments.
// ---------------------------------------------------------------------------
// The block keeps up to MAX_SEGMENTS segments (start, length, free flag) that
// tile [0, memory_size). An allocate word scans every free segment that fits,
// takes the one with the smallest leftover (lowest address on a tie), marks
// it allocated and inserts the remainder after it as a new free segment. A
// release word marks the segment that starts at release_start free, without
// merging neighbors. One result word comes back per request word: status 0 ok,
// 1 no fitting free segment, 2 table full, 3 zero size or start not found or
// already free; alloc_start carries the allocated start, the echoed release
// start, or 0 on failure. Writing cfg_wr_data resets the table to one free
// segment of that size, saturated into 1 .. 2^ADDR_BITS; do so only while no
// request is in flight. After reset the block writes the initial segment in
// its init state before it raises in_ready. Items are handled one at a time:
// each request scans every table entry and is then decided; an allocate
// that splits a segment also shifts the entries after the chosen one up by
// one and writes the free remainder; the result is then delivered.
// The pace of the scan and the shift-up is set by the single read port of the
// segment memory, which they walk one entry a cycle.
// The result waits in an output register, so a new word is taken while an
// earlier result is still unclaimed.
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_segment_allocator
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [ADDR_BITS:0]   cfg_wr_data,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_type,
    input  wire logic [ADDR_BITS:0]   req_size,
    input  wire logic [ADDR_BITS-1:0] release_start,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [ADDR_BITS-1:0]      alloc_start
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: walks the table through scan, decide and shift steps
    bfsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // segment memory, best-fit compare and result registers
    bfsa_datapath
    #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req_type      (req_type),
        .req_size      (req_size),
        .release_start (release_start),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .alloc_start   (alloc_start)
    );

endmodule

`default_nettype wire

[rtl/core/bfsa_checker.sv]
// ---------------------------------------------------------------------------
// bfsa_checker
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bfsa_checker
    import bfsa_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [STATUS_W-1:0]  status,
    input wire logic [ADDR_BITS-1:0] alloc_start
);

    // words accepted whose result has not been taken yet
    logic [1:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_valid && in_ready)
                           - 2'(out_valid && out_ready);
        end
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("result word without an outstanding request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in work");

    a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (alloc_start == '0))
        else $error("failed request returned a nonzero start");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
                                       && $stable(alloc_start)))
        else $error("stalled result word changed");

endmodule

bind best_fit_segment_allocator bfsa_checker
#(
    .ADDR_BITS (ADDR_BITS)
)
u_bfsa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .alloc_start (alloc_start)
);

`default_nettype wire

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the best-fit segment allocator.
// ---------------------------------------------------------------------------
// Request words go in on a valid/ready channel and each one returns exactly
// one result word. A scoreboard model of the segment table (start, length,
// free flag, entry count) runs alongside the block. Each accepted request is
// applied to the model, and the result it gives is queued. Each result word
// that comes back is compared against the oldest queued entry.
// A short scripted part covers the corner cases first: zero size, release of
// a free or unknown start, exact fit of the whole pool, no fit, a full table
// and memory sizes that saturate. Random traffic then runs over several pool
// sizes, with random gaps on both channels and one long output stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import bfsa_pkg::*;

    localparam int SEGS         = 16;
    localparam int AW           = 16;
    localparam int UW           = AW + 1;
    localparam int FULL_SPAN    = 1 << AW;
    localparam int RANDOM_WORDS = 1950;
    localparam int PHASES       = 8;
    localparam int QUIET_TAIL   = 150;
    // Long enough for a full table scan plus a full shift-up.
    localparam int DRAIN_GAP    = 48;
    localparam int LONG_HOLD    = 500;
    localparam int HOLD_AT      = 300;
    // Well above the slowest legal run, long hold and drains included.
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum logic { ROW_WORD, ROW_SIZE } row_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AW-1:0]       start;
    } reply_t;

    // One scripted step: either a request word, repeated reps times, or a
    // memory_size write carried in the size column.
    typedef struct packed {
        row_kind_t           kind;
        logic                op;
        logic [AW:0]         size;
        logic [AW-1:0]       base;
        logic [4:0]          reps;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [AW-1:0]       start;
    } row_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [AW:0]         cfg_wr_data   = '0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic                req_type      = REQ_ALLOC;
    logic [AW:0]         req_size      = '0;
    logic [AW-1:0]       release_start = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [AW-1:0]       alloc_start;

    // Scoreboard copy of the segment table.
    logic [AW-1:0] seg_base [SEGS];
    logic [AW:0]   seg_len  [SEGS];
    logic          seg_open [SEGS];
    int            seg_used;
    logic [AW:0]   pool_size;

    reply_t awaited_replies [$];
    int     faults       = 0;
    int     replies_seen = 0;
    int     words_sent   = 0;
    int     cycle_count  = 0;
    bit     calm         = 1'b0;
    bit     feed_gaps    = 1'b1;

    // Scripted corner cases. Rows with typed set carry their result inline;
    // the rest take it from the scoreboard.
    row_t script [15] = '{
        // zero size, release of a free start, release of an unknown start
        '{ROW_WORD, REQ_ALLOC,   17'd0,     16'd0,    5'd1,  1'b1, STATUS_BAD_REQ, 16'd0},
        '{ROW_WORD, REQ_RELEASE, 17'd0,     16'd0,    5'd1,  1'b1, STATUS_BAD_REQ, 16'd0},
        '{ROW_WORD, REQ_RELEASE, 17'd0,     16'hFFFF, 5'd1,  1'b1, STATUS_BAD_REQ, 16'd0},
        // whole pool as one exact fit, give it back, then split it
        '{ROW_WORD, REQ_ALLOC,   17'h10000, 16'd0,    5'd1,  1'b1, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_RELEASE, 17'd0,     16'd0,    5'd1,  1'b1, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'd1,     16'd0,    5'd1,  1'b1, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'hFFFF,  16'd0,    5'd1,  1'b1, STATUS_OK,      16'd1},
        // an oversized memory_size saturates to the full span
        '{ROW_SIZE, REQ_ALLOC,   17'h1FFFF, 16'd0,    5'd1,  1'b0, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'h10000, 16'd0,    5'd1,  1'b1, STATUS_OK,      16'd0},
        // memory_size of zero becomes one unit
        '{ROW_SIZE, REQ_ALLOC,   17'd0,     16'd0,    5'd1,  1'b0, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'd2,     16'd0,    5'd1,  1'b1, STATUS_NO_FIT,  16'd0},
        // fill the table with single units, then split fails, exact fit passes
        '{ROW_SIZE, REQ_ALLOC,   17'd20,    16'd0,    5'd1,  1'b0, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'd1,     16'd0,    5'd15, 1'b0, STATUS_OK,      16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'd2,     16'd0,    5'd1,  1'b1, STATUS_FULL,    16'd0},
        '{ROW_WORD, REQ_ALLOC,   17'd5,     16'd0,    5'd1,  1'b1, STATUS_OK,      16'd15}
    };

    logic [AW:0] phase_sizes [PHASES] = '{
        17'd64, 17'h10000, 17'd1, 17'd1000, 17'd16, 17'd2, 17'h10001, 17'd300
    };

    best_fit_segment_allocator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .req_size      (req_size),
        .release_start (release_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .alloc_start   (alloc_start)
    );

    always #4 clk = ~clk;

    // Saturate a written memory_size and rebuild the table as one free segment.
    function automatic void adopt_pool_size(input logic [AW:0] raw);
        logic [AW:0] units;
        int          i;
        units = raw;
        if (units == 0)
            units = 1;
        if (units > FULL_SPAN)
            units = UW'(FULL_SPAN);
        pool_size = units;
        for (i = 0; i < SEGS; i++)
        begin
            seg_base[i] = '0;
            seg_len[i]  = '0;
            seg_open[i] = 1'b0;
        end
        seg_len[0]  = units;
        seg_open[0] = 1'b1;
        seg_used    = 1;
    endfunction

    // Apply one request to the scoreboard table and return its result word.
    function automatic reply_t serve_request(input logic op, input logic [AW:0] units,
                                             input logic [AW-1:0] addr);
        reply_t      r;
        bit          found;
        int          best;
        int          i;
        logic [AW:0] spare;
        r.status = STATUS_BAD_REQ;
        r.start  = '0;
        found    = 1'b0;
        best     = 0;
        spare    = '0;
        if (op == REQ_RELEASE)
        begin
            // First entry with a matching start decides; a free one is an error.
            for (i = 0; i < seg_used; i++)
            begin
                if (seg_base[i] == addr)
                begin
                    if (!seg_open[i])
                    begin
                        seg_open[i] = 1'b1;
                        r.status    = STATUS_OK;
                        r.start     = addr;
                    end
                    return r;
                end
            end
            return r;
        end
        if (units == 0)
            return r;
        // Smallest leftover wins; strict compare keeps the lowest address on a tie.
        for (i = 0; i < seg_used; i++)
        begin
            if (seg_open[i] && seg_len[i] >= units && (!found || seg_len[i] - units < spare))
            begin
                found = 1'b1;
                best  = i;
                spare = seg_len[i] - units;
            end
        end
        if (!found)
        begin
            r.status = STATUS_NO_FIT;
            return r;
        end
        if (spare != 0)
        begin
            if (seg_used >= SEGS)
            begin
                r.status = STATUS_FULL;
                return r;
            end
            // Open a slot right after the chosen entry for the free remainder.
            for (i = seg_used; i > best + 1; i--)
            begin
                seg_base[i] = seg_base[i-1];
                seg_len[i]  = seg_len[i-1];
                seg_open[i] = seg_open[i-1];
            end
            seg_base[best+1] = seg_base[best] + units[AW-1:0];
            seg_len[best+1]  = spare;
            seg_open[best+1] = 1'b1;
            seg_used++;
        end
        seg_len[best]  = units;
        seg_open[best] = 1'b0;
        r.status       = STATUS_OK;
        r.start        = seg_base[best];
        return r;
    endfunction

    // Draw one random request. Most are well formed against the current table:
    // small allocations, exact fits of a free segment, releases of live
    // segments. The rest is noise: unknown starts, zero and oversized requests.
    task automatic pick_random_word(output logic op, output logic [AW:0] units,
                                    output logic [AW-1:0] addr);
        int          taken [$];
        int          open_idx [$];
        int          i;
        int          roll;
        logic [AW:0] light_cap;
        for (i = 0; i < seg_used; i++)
        begin
            if (seg_open[i])
                open_idx.push_back(i);
            else
                taken.push_back(i);
        end
        roll      = $urandom_range(0, 99);
        light_cap = (pool_size >> 3) + 1;
        op        = REQ_ALLOC;
        units     = UW'($urandom_range(1, light_cap));
        addr      = AW'($urandom);
        if (roll < 40)
            op = REQ_ALLOC;
        else if (roll < 48)
            units = UW'($urandom_range(1, pool_size));
        else if (roll < 56 && open_idx.size() != 0)
            units = seg_len[open_idx[$urandom_range(0, open_idx.size() - 1)]];
        else if (roll < 86 && taken.size() != 0)
        begin
            op   = REQ_RELEASE;
            addr = seg_base[taken[$urandom_range(0, taken.size() - 1)]];
        end
        else if (roll < 93)
            op = REQ_RELEASE;
        else if (roll < 96)
            units = '0;
        else
            units = UW'($urandom_range(0, FULL_SPAN));
    endtask

    // Offer one request word and hold it until taken. Queue its result at the
    // accepting edge; a typed row queues its inline result instead.
    task automatic send_word(input logic op, input logic [AW:0] units,
                             input logic [AW-1:0] addr, input bit typed,
                             input reply_t fixed);
        reply_t predicted;
        words_sent++;
        if (words_sent % 64 == 0)
            feed_gaps = ($urandom_range(0, 2) != 0);
        if (!calm && feed_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= op;
        req_size      <= units;
        release_start <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = serve_request(op, units, addr);
        awaited_replies.push_back(typed ? fixed : predicted);
    endtask

    // Drop valid, drain every result, let the block settle, then write
    // memory_size and rebuild the scoreboard table to match.
    task automatic write_pool_size(input logic [AW:0] raw);
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= raw;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        adopt_pool_size(raw);
    endtask

    // Request side: reset, scripted rows, then random phases.
    initial
    begin
        row_t          row;
        reply_t        fixed;
        logic          op;
        logic [AW:0]   units;
        logic [AW-1:0] addr;
        int            p;
        int            n;
        adopt_pool_size(UW'(FULL_SPAN));
        phase_sizes[5] = UW'($urandom_range(2, FULL_SPAN));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            row          = script[k];
            fixed.status = row.status;
            fixed.start  = row.start;
            if (row.kind == ROW_SIZE)
                write_pool_size(row.size);
            else
                repeat (row.reps) send_word(row.op, row.size, row.base, row.typed, fixed);
        end

        for (p = 0; p < PHASES; p++)
        begin
            write_pool_size(phase_sizes[p]);
            for (n = 0; n < RANDOM_WORDS / PHASES; n++)
            begin
                // Run the tail of the last phase with no gaps on either side.
                if (p == PHASES - 1 && n >= RANDOM_WORDS / PHASES - QUIET_TAIL)
                    calm = 1'b1;
                pick_random_word(op, units, addr);
                send_word(op, units, addr, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: check each accepted word, then pick the next out_ready.
    // Stall in short random bursts, and once hold off for a long stretch so
    // the output register and the request side back up.
    initial
    begin
        reply_t want;
        int     stall_left;
        bit     stall_mode;
        bit     held;
        stall_left = 0;
        stall_mode = 1'b1;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                replies_seen++;
                if (replies_seen % 64 == 0)
                    stall_mode = ($urandom_range(0, 2) != 0);
                if (awaited_replies.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected result: status %0d start %0d",
                                 status, alloc_start);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (status !== want.status || alloc_start !== want.start)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display({"result %0d: expected status %0d start %0d,",
                                      " got status %0d start %0d"},
                                     replies_seen, want.status, want.start,
                                     status, alloc_start);
                    end
                end
            end
            if (!held && replies_seen >= HOLD_AT)
            begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && stall_mode && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if it outlives any plausible correct run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[best_fit_segment_allocator.f]
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_ctrl.sv
rtl/core/bfsa_datapath.sv
rtl/core/best_fit_segment_allocator.sv
rtl/core/bfsa_checker.sv
test/tb_top.sv
